// File: rtl/core/pulse_width_frame_transmitter_core_assert.svh
// Assertion macros for the pulse-width frame transmitter core.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef PULSE_WIDTH_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`define PULSE_WIDTH_FRAME_TRANSMITTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PWFT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pwft assertion failed");

// Next-cycle implication, checked outside reset.
`define PWFT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pwft assertion failed");

`endif

// File: rtl/core/pwft_pkg.sv
// Package for the pulse-width frame transmitter core.
// Request codes, frame phases, register indexes and timing helpers; no dependencies.
`default_nettype none

package pwft_pkg;

  localparam int unsigned CmdW   = 16;
  localparam int unsigned UnitW  = 4;
  localparam int unsigned WaitW  = 8;
  localparam int unsigned CfgIdxW = 3;

  // Frame durations in half-ms units.
  localparam logic [4:0] HdrLowUnits = 5'd8;
  localparam logic [4:0] ShortUnits  = 5'd1;
  localparam logic [4:0] LongUnits   = 5'd3;
  localparam logic [4:0] GapUnits    = 5'd24;
  localparam logic [UnitW-1:0] UnitMax = 4'd10;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_OR    = 3'd2,
    REQ_XOR   = 3'd3,
    REQ_AND   = 3'd4
  } req_e;

  // Phase names say what the next completed wait starts.
  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_HDR_END  = 3'd1,
    PH_BIT      = 3'd2,
    PH_ZERO_END = 3'd3,
    PH_ONE_END  = 3'd4,
    PH_CLOSE    = 3'd5,
    PH_GAP      = 3'd6
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICKS   = 3'd0,
    CFG_START   = 3'd1,
    CFG_IDLE    = 3'd2,
    CFG_STOP    = 3'd3,
    CFG_CANNON  = 3'd4,
    CFG_HIT     = 3'd5,
    CFG_DESTROY = 3'd6
  } cfg_idx_e;

  // n units of the configured length; unit clamps at UnitMax so all fit 8 bits.
  function automatic logic [WaitW-1:0] unit_ticks(logic [4:0] n, logic [UnitW-1:0] tph);
    logic [UnitW-1:0] u;
    logic [8:0]       p;
    u = (tph > UnitMax) ? UnitMax : tph;
    p = n * u;
    return p[WaitW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/pulse_width_frame_transmitter_core.sv
// Pulse-width frame transmitter core: top level.
// Depends on pwft_pkg and pulse_width_frame_transmitter_core_assert.svh.
`default_nettype none

// Drives a pulse-width coded line that repeats a frame forever: header low 8 /
// high 1 unit, FRAME_BITS command bits MSB first (one = low 3 / high 1, zero =
// low 1 / high 3), closing low 1 and gap high 24. A unit is ticks_per_half_ms
// tick beats (clamped to 10, zero gives one-beat phases). Each input beat is
// either a tick or an atomic write/OR/XOR/AND of the command word; every beat
// yields exactly one output beat with the line level and command word after
// it. Rate: one beat per clock cycle while the output is not stalled; each
// output beat follows in the cycle after its input beat is accepted. The
// state update happens at the input handshake and the result sits in a
// single output register, which is the only pipeline stage; s_axis_tready
// stays high while that register is empty or being drained, so a stalled
// output only holds the input off once the register is full. Entering the
// gap, one-shot bits (start, stop, cannon, hit, destroy, in that order) are
// armed on one frame and retired on the next, sharing one flag; then the
// word is latched for the next frame. Config writes must happen while idle.

`include "pulse_width_frame_transmitter_core_assert.svh"

module pulse_width_frame_transmitter_core #(
  parameter int unsigned FRAME_BITS = 16   // 1 to 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] bits_value
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] req_type
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [0] line_level, [16:1] command_now, zero fill
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int unsigned CmdW = pwft_pkg::CmdW;
  localparam int unsigned WaitW = pwft_pkg::WaitW;
  localparam int unsigned BitW = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam logic [BitW-1:0] LastBit = BitW'(FRAME_BITS - 1);

  // ---------------- configuration registers ----------------
  logic [pwft_pkg::UnitW-1:0] ticks_q;
  logic [CmdW-1:0] start_mask_q, idle_mask_q, stop_mask_q;
  logic [CmdW-1:0] cannon_mask_q, hit_mask_q, destroy_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q        <= 4'd8;
      start_mask_q   <= '0;
      idle_mask_q    <= '0;
      stop_mask_q    <= '0;
      cannon_mask_q  <= '0;
      hit_mask_q     <= '0;
      destroy_mask_q <= '0;
    end else if (cfg_we_i) begin
      case (pwft_pkg::cfg_idx_e'(cfg_addr_i))
        pwft_pkg::CFG_TICKS:   ticks_q        <= cfg_wdata_i[pwft_pkg::UnitW-1:0];
        pwft_pkg::CFG_START:   start_mask_q   <= cfg_wdata_i;
        pwft_pkg::CFG_IDLE:    idle_mask_q    <= cfg_wdata_i;
        pwft_pkg::CFG_STOP:    stop_mask_q    <= cfg_wdata_i;
        pwft_pkg::CFG_CANNON:  cannon_mask_q  <= cfg_wdata_i;
        pwft_pkg::CFG_HIT:     hit_mask_q     <= cfg_wdata_i;
        pwft_pkg::CFG_DESTROY: destroy_mask_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- frame state ----------------
  pwft_pkg::phase_e phase_q, phase_d;
  logic [WaitW-1:0] target_q, target_d;
  logic [WaitW-1:0] count_q, count_d;
  logic [BitW-1:0]  bit_idx_q, bit_idx_d;
  logic [CmdW-1:0]  shift_q, shift_d;
  logic             armed_q, armed_d;
  logic [CmdW-1:0]  cmd_q, cmd_d;
  logic             line_q, line_d;

  logic out_valid_q;
  logic out_line_q;
  logic [CmdW-1:0] out_cmd_q;

  logic accept;
  logic [WaitW-1:0] count_inc;
  logic             wait_done;
  pwft_pkg::req_e   req;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = pwft_pkg::req_e'(s_axis_tuser);
  assign count_inc     = count_q + 1'b1;
  assign wait_done     = (count_inc >= target_q);

  // Apply one one-shot check; returns updated flag, match-and-retire in fire.
  function automatic logic [1:0] one_shot(logic [CmdW-1:0] word, logic [CmdW-1:0] mask,
                                          logic armed);
    logic hit;
    hit = |(word & mask);
    if (!hit) return {1'b0, armed};
    if (armed) return {1'b1, 1'b0};
    return {1'b0, 1'b1};
  endfunction

  always_comb begin
    logic [1:0] r;
    logic [CmdW-1:0] w;
    logic a;
    phase_d   = phase_q;
    target_d  = target_q;
    count_d   = count_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    armed_d   = armed_q;
    cmd_d     = cmd_q;
    line_d    = line_q;
    w         = cmd_q;
    a         = armed_q;
    r         = '0;
    case (req)
      pwft_pkg::REQ_TICK: begin
        count_d = count_inc;
        if (wait_done) begin
          count_d = '0;
          case (phase_q)
            pwft_pkg::PH_HDR_END: begin
              line_d   = 1'b1;
              target_d = pwft_pkg::unit_ticks(pwft_pkg::ShortUnits, ticks_q);
              phase_d  = pwft_pkg::PH_BIT;
            end
            pwft_pkg::PH_BIT: begin
              line_d = 1'b0;
              if (shift_q[FRAME_BITS-1]) begin
                target_d = pwft_pkg::unit_ticks(pwft_pkg::LongUnits, ticks_q);
                phase_d  = pwft_pkg::PH_ONE_END;
              end else begin
                target_d = pwft_pkg::unit_ticks(pwft_pkg::ShortUnits, ticks_q);
                phase_d  = pwft_pkg::PH_ZERO_END;
              end
            end
            pwft_pkg::PH_ZERO_END, pwft_pkg::PH_ONE_END: begin
              line_d   = 1'b1;
              target_d = (phase_q == pwft_pkg::PH_ZERO_END)
                       ? pwft_pkg::unit_ticks(pwft_pkg::LongUnits, ticks_q)
                       : pwft_pkg::unit_ticks(pwft_pkg::ShortUnits, ticks_q);
              if (bit_idx_q == LastBit) begin
                bit_idx_d = '0;
                phase_d   = pwft_pkg::PH_CLOSE;
              end else begin
                bit_idx_d = bit_idx_q + 1'b1;
                shift_d   = {shift_q[CmdW-2:0], 1'b0};
                phase_d   = pwft_pkg::PH_BIT;
              end
            end
            pwft_pkg::PH_CLOSE: begin
              line_d   = 1'b0;
              target_d = pwft_pkg::unit_ticks(pwft_pkg::ShortUnits, ticks_q);
              phase_d  = pwft_pkg::PH_GAP;
            end
            pwft_pkg::PH_GAP: begin
              line_d   = 1'b1;
              target_d = pwft_pkg::unit_ticks(pwft_pkg::GapUnits, ticks_q);
              // one-shot chain, in fixed order, sharing one flag
              r = one_shot(w, start_mask_q, a);
              a = r[0];
              if (r[1]) w = (w & ~start_mask_q) | idle_mask_q;
              r = one_shot(w, stop_mask_q, a);
              a = r[0];
              if (r[1]) w = '0;
              r = one_shot(w, cannon_mask_q, a);
              a = r[0];
              if (r[1]) w = w & ~cannon_mask_q;
              r = one_shot(w, hit_mask_q, a);
              a = r[0];
              if (r[1]) w = w & ~hit_mask_q;
              r = one_shot(w, destroy_mask_q, a);
              a = r[0];
              if (r[1]) w = w & ~destroy_mask_q;
              armed_d = a;
              cmd_d   = w;
              shift_d = w;
              phase_d = pwft_pkg::PH_HEADER;
            end
            default: begin
              line_d   = 1'b0;
              target_d = pwft_pkg::unit_ticks(pwft_pkg::HdrLowUnits, ticks_q);
              phase_d  = pwft_pkg::PH_HDR_END;
            end
          endcase
        end
      end
      pwft_pkg::REQ_WRITE: cmd_d = s_axis_tdata;
      pwft_pkg::REQ_OR:    cmd_d = cmd_q | s_axis_tdata;
      pwft_pkg::REQ_XOR:   cmd_d = cmd_q ^ s_axis_tdata;
      pwft_pkg::REQ_AND:   cmd_d = cmd_q & s_axis_tdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pwft_pkg::PH_HEADER;
      target_q  <= '0;
      count_q   <= '0;
      bit_idx_q <= '0;
      shift_q   <= '0;
      armed_q   <= 1'b0;
      cmd_q     <= '0;
      line_q    <= 1'b1;
    end else if (accept) begin
      phase_q   <= phase_d;
      target_q  <= target_d;
      count_q   <= count_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      armed_q   <= armed_d;
      cmd_q     <= cmd_d;
      line_q    <= line_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_line_q <= line_d;
      out_cmd_q  <= cmd_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_cmd_q, out_line_q};

  // ---------------- assertions ----------------
  `PWFT_ASSERT_NEXT(a_accept_gives_beat, accept, out_valid_q)
  `PWFT_ASSERT_NEXT(a_update_keeps_timing, accept && (req != pwft_pkg::REQ_TICK),
                    $stable(count_q) && $stable(phase_q))
  `PWFT_ASSERT_NOW(a_bit_idx_zero_outside_bits,
                   (phase_q == pwft_pkg::PH_CLOSE) || (phase_q == pwft_pkg::PH_GAP) ||
                   (phase_q == pwft_pkg::PH_HEADER) || (phase_q == pwft_pkg::PH_HDR_END),
                   bit_idx_q == '0)
  `PWFT_ASSERT_NEXT(a_gap_enters_header,
                    accept && (req == pwft_pkg::REQ_TICK) && wait_done &&
                    (phase_q == pwft_pkg::PH_GAP),
                    (phase_q == pwft_pkg::PH_HEADER) && line_q && (shift_q == cmd_q))

endmodule

`default_nettype wire
